// ===== design/oal_pkg.sv =====
// Package for the ordered array list engine.
// Holds the sizes, operation and status codes, and the controller/datapath structs.
// No dependencies.
package oal_pkg;

  // Storage size
  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Field widths of the channels
  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int FPOS_W  = 7;
  localparam int COUNT_W = 7;

  // Common width for index and count compares
  localparam int WIDE_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_ERASE_POS = 3'd1,
    OP_ERASE_VAL = 3'd2,
    OP_FIND      = 3'd3,
    OP_GET       = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Walk setup selected by the controller
  typedef enum logic [2:0] {
    INIT_INS     = 3'd0,
    INIT_ERA_POS = 3'd1,
    INIT_ERA_HIT = 3'd2,
    INIT_SCAN    = 3'd3,
    INIT_GET     = 3'd4
  } init_t;

  typedef enum logic [1:0] {
    MODE_UP   = 2'd0,
    MODE_DN   = 2'd1,
    MODE_SCAN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    FP_ZERO = 2'd0,
    FP_HIT  = 2'd1,
    FP_CNT  = 2'd2
  } fpos_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      init;
    init_t     init_sel;
    logic      run;
    logic      shift_wr;
    logic      final_wr;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cnt_clr;
    logic      cap_hit;
    logic      publish;
    status_t   status;
    logic      rd_sel;
    fpos_sel_t fpos_sel;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t  op;
    logic ins_range;
    logic full;
    logic idx_range;
    logic done;
    logic hit;
  } dp_stat_t;

endpackage

// ===== design/oal_if.sv =====
// Channel interfaces for the ordered array list engine: request and result.
// Depends on oal_pkg for field widths.
interface oal_in_if;
  import oal_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] element_value;

  modport source (output valid, output operation, output position, output element_value,
                  input ready);
  modport sink (input valid, input operation, input position, input element_value,
                output ready);
endinterface

interface oal_out_if;
  import oal_pkg::*;
  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [VAL_W-1:0]   read_value;
  logic [FPOS_W-1:0]  found_position;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output status, output read_value, output found_position,
                  output count, input ready);
  modport sink (input valid, input status, input read_value, input found_position,
                input count, output ready);
endinterface

// ===== design/oal_ctrl.sv =====
// Controller state machine of the ordered array list engine.
// Sequences decode, memory walks and the result handshake; depends on oal_pkg.
module oal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  oal_pkg::dp_stat_t stat,
  output oal_pkg::dp_cmd_t  cmd
);
  import oal_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_SHIFT_UP = 8'b0000_0100,
    S_INS_WR   = 8'b0000_1000,
    S_SHIFT_DN = 8'b0001_0000,
    S_SCAN     = 8'b0010_0000,
    S_GET_RD   = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    cmd           = '0;
    cmd.init_sel  = INIT_SCAN;
    cmd.status    = st_r;
    cmd.fpos_sel  = FP_ZERO;
    state_nxt     = state_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          st_nxt    = ST_OK;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.ins_range) begin
              st_nxt    = ST_RANGE;
              state_nxt = S_RESP;
            end else if (stat.full) begin
              st_nxt    = ST_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd.init     = 1'b1;
              cmd.init_sel = INIT_INS;
              state_nxt    = S_SHIFT_UP;
            end
          end
          OP_ERASE_POS: begin
            if (stat.idx_range) begin
              st_nxt    = ST_RANGE;
              state_nxt = S_RESP;
            end else begin
              cmd.init     = 1'b1;
              cmd.init_sel = INIT_ERA_POS;
              state_nxt    = S_SHIFT_DN;
            end
          end
          OP_ERASE_VAL, OP_FIND: begin
            cmd.init     = 1'b1;
            cmd.init_sel = INIT_SCAN;
            state_nxt    = S_SCAN;
          end
          OP_GET: begin
            if (stat.idx_range) begin
              st_nxt    = ST_RANGE;
              state_nxt = S_RESP;
            end else begin
              cmd.init     = 1'b1;
              cmd.init_sel = INIT_GET;
              state_nxt    = S_GET_RD;
            end
          end
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_RESP;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end

      // Move entries up by one, then drop the new value in
      S_SHIFT_UP: begin
        cmd.run      = 1'b1;
        cmd.shift_wr = 1'b1;
        if (stat.done) begin
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        cmd.final_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        state_nxt    = S_RESP;
      end

      // Move entries down by one over the erased slot
      S_SHIFT_DN: begin
        cmd.run      = 1'b1;
        cmd.shift_wr = 1'b1;
        if (stat.done) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_RESP;
        end
      end

      // Compare stored entries against the key in order
      S_SCAN: begin
        cmd.run = 1'b1;
        if (stat.hit) begin
          if (stat.op == OP_FIND) begin
            cmd.cap_hit = 1'b1;
            state_nxt   = S_RESP;
          end else begin
            cmd.init     = 1'b1;
            cmd.init_sel = INIT_ERA_HIT;
            state_nxt    = S_SHIFT_DN;
          end
        end else if (stat.done) begin
          st_nxt    = ST_NOTFOUND;
          state_nxt = S_RESP;
        end
      end

      S_GET_RD: begin
        cmd.run = 1'b1;
        if (stat.done) begin
          state_nxt = S_RESP;
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        cmd.rd_sel = (stat.op == OP_GET) && (st_r == ST_OK);
        if (stat.op == OP_FIND) begin
          cmd.fpos_sel = (st_r == ST_OK) ? FP_HIT : FP_CNT;
        end
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/oal_datapath.sv =====
// Datapath of the ordered array list engine: entry memory, walk pointers,
// element count, key compare and result register. Depends on oal_pkg.
module oal_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  oal_pkg::dp_cmd_t            cmd,
  output oal_pkg::dp_stat_t           stat,
  input  logic [oal_pkg::OP_W-1:0]    in_operation,
  input  logic [oal_pkg::POS_W-1:0]   in_position,
  input  logic [oal_pkg::VAL_W-1:0]   in_element_value,
  output logic [oal_pkg::ST_W-1:0]    out_status,
  output logic [oal_pkg::VAL_W-1:0]   out_read_value,
  output logic [oal_pkg::FPOS_W-1:0]  out_found_position,
  output logic [oal_pkg::COUNT_W-1:0] out_count
);
  import oal_pkg::*;

  // Request registers
  op_t                   op_r;
  logic [POS_W-1:0]      pos_r;
  logic [ELEM_WIDTH-1:0] key_r;

  // Walk state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] waddr_r, waddr_nxt;
  logic [CNT_W-1:0] hidx_r;
  mode_t            mode_r, mode_nxt;
  logic             pv_r;

  // Memory
  logic [ELEM_WIDTH-1:0] mem_r [DEPTH];
  logic [ELEM_WIDTH-1:0] rdata_r;
  logic                  rd_en;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;

  // Result register
  logic [ST_W-1:0]    res_status_r;
  logic [VAL_W-1:0]   res_rd_r;
  logic [FPOS_W-1:0]  res_fpos_r;
  logic [COUNT_W-1:0] res_count_r;

  logic [WIDE_W-1:0] pos_w, cnt_w, hit_w;

  assign pos_w = WIDE_W'(pos_r);
  assign cnt_w = WIDE_W'(cnt_r);
  assign hit_w = WIDE_W'(waddr_r);

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_operation);
      pos_r <= in_position;
      key_r <= in_element_value[ELEM_WIDTH-1:0];
    end
  end

  // Walk setup and advance
  always_comb begin
    rptr_nxt  = rptr_r;
    rem_nxt   = rem_r;
    mode_nxt  = mode_r;
    waddr_nxt = waddr_r;
    rd_en     = 1'b0;
    if (cmd.init) begin
      case (cmd.init_sel)
        INIT_INS: begin
          rptr_nxt = CNT_W'(cnt_w - WIDE_W'(1));
          rem_nxt  = CNT_W'(cnt_w - pos_w);
          mode_nxt = MODE_UP;
        end
        INIT_ERA_POS: begin
          rptr_nxt = CNT_W'(pos_w + WIDE_W'(1));
          rem_nxt  = CNT_W'(cnt_w - WIDE_W'(1) - pos_w);
          mode_nxt = MODE_DN;
        end
        INIT_ERA_HIT: begin
          rptr_nxt = CNT_W'(hit_w + WIDE_W'(1));
          rem_nxt  = CNT_W'(cnt_w - WIDE_W'(1) - hit_w);
          mode_nxt = MODE_DN;
        end
        INIT_GET: begin
          rptr_nxt = CNT_W'(pos_w);
          rem_nxt  = CNT_W'(1);
          mode_nxt = MODE_SCAN;
        end
        default: begin
          rptr_nxt = '0;
          rem_nxt  = cnt_r;
          mode_nxt = MODE_SCAN;
        end
      endcase
    end else if (cmd.run && (rem_r != '0)) begin
      rd_en   = 1'b1;
      rem_nxt = rem_r - CNT_W'(1);
      case (mode_r)
        MODE_UP: begin
          rptr_nxt  = rptr_r - CNT_W'(1);
          waddr_nxt = rptr_r + CNT_W'(1);
        end
        MODE_DN: begin
          rptr_nxt  = rptr_r + CNT_W'(1);
          waddr_nxt = rptr_r - CNT_W'(1);
        end
        default: begin
          rptr_nxt  = rptr_r + CNT_W'(1);
          waddr_nxt = rptr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      pv_r  <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      pv_r  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rptr_r  <= rptr_nxt;
    mode_r  <= mode_nxt;
    waddr_r <= waddr_nxt;
    if (cmd.cap_hit) begin
      hidx_r <= waddr_r;
    end
  end

  // Memory: one write and one registered read a cycle
  assign mem_we    = (cmd.shift_wr && pv_r) || cmd.final_wr;
  assign mem_waddr = cmd.final_wr ? pos_w[IDX_W-1:0] : waddr_r[IDX_W-1:0];
  assign mem_wdata = cmd.final_wr ? key_r : rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rptr_r[IDX_W-1:0]];
    end
  end

  // Element count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Status toward the controller
  assign stat.op        = op_r;
  assign stat.ins_range = (pos_w > cnt_w);
  assign stat.full      = (cnt_w >= WIDE_W'(DEPTH));
  assign stat.idx_range = (pos_w >= cnt_w);
  assign stat.done      = (rem_r == '0) && !pv_r;
  assign stat.hit       = pv_r && (mode_r == MODE_SCAN) && (rdata_r == key_r);

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      res_status_r <= cmd.status;
      res_rd_r     <= cmd.rd_sel ? VAL_W'(rdata_r) : '0;
      case (cmd.fpos_sel)
        FP_HIT:  res_fpos_r <= FPOS_W'(hidx_r);
        FP_CNT:  res_fpos_r <= FPOS_W'(cnt_r);
        default: res_fpos_r <= '0;
      endcase
      res_count_r  <= COUNT_W'(cnt_r);
    end
  end

  assign out_status         = res_status_r;
  assign out_read_value     = res_rd_r;
  assign out_found_position = res_fpos_r;
  assign out_count          = res_count_r;

endmodule

// ===== design/ordered_array_list_engine.sv =====
// Ordered array list engine: clear, rejected and unused requests go straight to the result,
// while get, insert, find and erase first walk the entry memory at one entry per cycle.
// One request is in work at a time; the next one is taken the cycle after the result is
// registered. Reset (rst_n, synchronous) empties the list; entries keep whatever they held
// and are only read below the count.
module ordered_array_list_engine (
  input logic      clk,
  input logic      rst_n,
  oal_in_if.sink   in_ch,
  oal_out_if.source out_ch
);
  import oal_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencing
  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and compare
  oal_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_ch.operation),
    .in_position        (in_ch.position),
    .in_element_value   (in_ch.element_value),
    .out_status         (out_ch.status),
    .out_read_value     (out_ch.read_value),
    .out_found_position (out_ch.found_position),
    .out_count          (out_ch.count)
  );

  // One request at a time: ready drops after each transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while another is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.count <= COUNT_W'(DEPTH)))
    else $error("count beyond capacity");

  a_fpos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.found_position <= out_ch.count))
    else $error("found position beyond count");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.read_value != '0)) |-> (out_ch.status == ST_OK))
    else $error("read data on a failed request");

endmodule
